// ===== hdl/integer_calculator_alu_assert.svh =====
// assertion macros for the integer calculator alu
// used by the checker module, no other dependencies
`ifndef INTEGER_CALCULATOR_ALU_ASSERT_SVH
`define INTEGER_CALCULATOR_ALU_ASSERT_SVH

// check a property at every rising edge, idle while reset is high
`define ICA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define ICA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ica_pkg.sv =====
// package for the integer calculator alu: word types, codes, helpers
// no dependencies
`timescale 1ns / 1ps

package ica_pkg;

  // operation codes
  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_SUB  = 3'd1;
  localparam logic [2:0] MODE_MUL  = 3'd2;
  localparam logic [2:0] MODE_DIV  = 3'd3;
  localparam logic [2:0] MODE_POW  = 3'd4;
  localparam logic [2:0] MODE_SQRT = 3'd5;
  localparam logic [2:0] MODE_PCT  = 3'd6;

  // error codes
  localparam logic [1:0] ERR_OK           = 2'd0;
  localparam logic [1:0] ERR_DIV_ZERO     = 2'd1;
  localparam logic [1:0] ERR_NEG_ROOT     = 2'd2;
  localparam logic [1:0] ERR_ZERO_NEG_POW = 2'd3;

  localparam logic [31:0] PERCENT_DIVISOR = 32'd100;
  localparam logic [31:0] SQRT_FIRST_BIT  = 32'h4000_0000;

  // operations of the shared unit
  typedef enum logic [1:0] {
    UOP_ADD,
    UOP_SUB,
    UOP_MUL
  } uop_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } cmd_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         error_code;
  } rsp_word_t;

  // magnitude of a two's complement word, -2^31 maps to 2^31
  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

endpackage

// ===== hdl/ica_shared_unit.sv =====
// shared arithmetic unit: 33-bit add/subtract with borrow out, 32-bit wrapping multiply
// depends on ica_pkg
`timescale 1ns / 1ps

module ica_shared_unit (
  input  ica_pkg::uop_t uop,
  input  logic [32:0]   x,
  input  logic [32:0]   y,
  output logic [33:0]   r
);

  logic [31:0] prod;

  assign prod = x[31:0] * y[31:0];

  always_comb begin
    case (uop)
      ica_pkg::UOP_ADD: r = {1'b0, x} + {1'b0, y};
      ica_pkg::UOP_SUB: r = {1'b0, x} - {1'b0, y};  // bit 33 is the borrow
      ica_pkg::UOP_MUL: r = {2'b00, prod};
      default:          r = '0;
    endcase
  end

endmodule

// ===== hdl/integer_calculator_alu.sv =====
// add, sub, mul and mode 7 go from prep to done; divide runs div steps, then fix;
// percent multiplies, then divides; root loops in sqrt; power in pow_mul and pow_sq
// throughput: one word at a time, the next command is taken after the result leaves
// the shared unit (one adder/subtractor and one multiplier) bounds every step
// reset (rst, synchronous, active high) returns the sequencer to idle, no result pending
`timescale 1ns / 1ps

// top level: command sequencer and working registers around ica_shared_unit
// depends on ica_pkg and ica_shared_unit
module integer_calculator_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ica_pkg::cmd_word_t cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ica_pkg::rsp_word_t rsp_word
);

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_PREP    = 8'b0000_0010,
    S_DIV     = 8'b0000_0100,
    S_FIX     = 8'b0000_1000,
    S_POW_MUL = 8'b0001_0000,
    S_POW_SQ  = 8'b0010_0000,
    S_SQRT    = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t      state;
  logic [2:0]  op;         // operation being worked, percent turns into divide
  logic [31:0] opa;        // operand a, power base, root remainder
  logic [31:0] opb;        // operand b, divisor, exponent, root bit
  logic [31:0] acc;        // dividend/quotient, power accumulator, root
  logic [31:0] rem;        // partial remainder of the divide
  logic        neg;        // quotient sign
  logic [4:0]  cnt;        // divide step counter
  logic [31:0] res_value;
  logic [1:0]  res_err;

  // shared unit hookup
  ica_pkg::uop_t uop;
  logic [32:0]   ux;
  logic [32:0]   uy;
  logic [33:0]   ures;
  logic          borrow;
  logic [31:0]   root_next;

  ica_shared_unit u_unit (
    .uop (uop),
    .x   (ux),
    .y   (uy),
    .r   (ures)
  );

  assign borrow = ures[33];

  // root bits sit above the trial bit, so or-ing gives root + bit
  assign root_next = borrow ? (acc >> 1) : ((acc >> 1) | opb);

  // handshake: one word in flight, result held in its own register
  assign cmd_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);
  assign rsp_word  = {res_value, res_err};

  // operand selection for the shared unit per sequencer step
  always_comb begin
    uop = ica_pkg::UOP_ADD;
    ux  = {1'b0, opa};
    uy  = {1'b0, opb};
    case (state)
      S_PREP: begin
        case (op)
          ica_pkg::MODE_SUB: uop = ica_pkg::UOP_SUB;
          ica_pkg::MODE_MUL,
          ica_pkg::MODE_PCT: uop = ica_pkg::UOP_MUL;
          default:           uop = ica_pkg::UOP_ADD;
        endcase
      end
      S_DIV: begin
        // trial subtract of the divisor from the shifted remainder
        uop = ica_pkg::UOP_SUB;
        ux  = {rem, acc[31]};
        uy  = {1'b0, opb};
      end
      S_FIX: begin
        // negate the quotient
        uop = ica_pkg::UOP_SUB;
        ux  = '0;
        uy  = {1'b0, acc};
      end
      S_POW_MUL: begin
        uop = ica_pkg::UOP_MUL;
        ux  = {1'b0, acc};
        uy  = {1'b0, opa};
      end
      S_POW_SQ: begin
        uop = ica_pkg::UOP_MUL;
        ux  = {1'b0, opa};
        uy  = {1'b0, opa};
      end
      S_SQRT: begin
        uop = ica_pkg::UOP_SUB;
        ux  = {1'b0, opa};
        uy  = {1'b0, acc | opb};
      end
      default: begin
        uop = ica_pkg::UOP_ADD;
      end
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op      <= cmd_word.mode;
            opa     <= cmd_word.operand_a;
            opb     <= cmd_word.operand_b;
            res_err <= ica_pkg::ERR_OK;
            state   <= S_PREP;
          end
        end
        S_PREP: begin
          case (op)
            ica_pkg::MODE_ADD,
            ica_pkg::MODE_SUB,
            ica_pkg::MODE_MUL: begin
              res_value <= ures[31:0];
              state     <= S_DONE;
            end
            ica_pkg::MODE_DIV: begin
              if (opb == '0) begin
                res_value <= '0;
                res_err   <= ica_pkg::ERR_DIV_ZERO;
                state     <= S_DONE;
              end else begin
                acc   <= ica_pkg::abs32(opa);
                opb   <= ica_pkg::abs32(opb);
                rem   <= '0;
                neg   <= opa[31] ^ opb[31];
                cnt   <= '0;
                state <= S_DIV;
              end
            end
            ica_pkg::MODE_PCT: begin
              // wrapped product, then a divide by the constant
              opa <= ures[31:0];
              opb <= ica_pkg::PERCENT_DIVISOR;
              op  <= ica_pkg::MODE_DIV;
            end
            ica_pkg::MODE_POW: begin
              if (opb[31]) begin
                // negative exponent: truncated result
                if (opa == '0) begin
                  res_value <= '0;
                  res_err   <= ica_pkg::ERR_ZERO_NEG_POW;
                end else if (opa == 32'd1) begin
                  res_value <= 32'd1;
                end else if (&opa) begin
                  res_value <= opb[0] ? '1 : 32'd1;
                end else begin
                  res_value <= '0;
                end
                state <= S_DONE;
              end else begin
                acc   <= 32'd1;
                state <= S_POW_MUL;
              end
            end
            ica_pkg::MODE_SQRT: begin
              if (opa[31]) begin
                res_value <= '0;
                res_err   <= ica_pkg::ERR_NEG_ROOT;
                state     <= S_DONE;
              end else begin
                acc   <= '0;
                opb   <= ica_pkg::SQRT_FIRST_BIT;
                state <= S_SQRT;
              end
            end
            default: begin
              // unused code: zero, no error
              res_value <= '0;
              state     <= S_DONE;
            end
          endcase
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle
          acc <= {acc[30:0], ~borrow};
          rem <= borrow ? {rem[30:0], acc[31]} : ures[31:0];
          cnt <= cnt + 5'd1;
          if (&cnt) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          res_value <= neg ? ures[31:0] : acc;
          state     <= S_DONE;
        end
        S_POW_MUL: begin
          // square and multiply, exponent bits from the bottom
          if (opb == '0) begin
            res_value <= acc;
            state     <= S_DONE;
          end else begin
            if (opb[0]) begin
              acc <= ures[31:0];
            end
            state <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          opa   <= ures[31:0];
          opb   <= opb >> 1;
          state <= S_POW_MUL;
        end
        S_SQRT: begin
          // digit by digit root, two radicand bits a cycle
          if (!borrow) begin
            opa <= ures[31:0];
          end
          acc <= root_next;
          opb <= opb >> 2;
          if (opb[0]) begin
            res_value <= root_next;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ica_checker.sv =====
// port-level checker for integer_calculator_alu, bound to the top level
// depends on ica_pkg and integer_calculator_alu_assert.svh
`timescale 1ns / 1ps
`include "integer_calculator_alu_assert.svh"

module ica_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input ica_pkg::rsp_word_t rsp_word
);

  // a held result keeps its word
  `ICA_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word), "result word dropped or changed while stalled")

  // one word in flight: never ready for a command while a result is shown
  `ICA_ASSERT(a_one_in_flight, clk, rst, !(cmd_ready && rsp_valid), "command taken while a result is pending")

  // no result in the cycle right after a command is taken
  `ICA_ASSERT(a_min_latency, clk, rst, cmd_valid && cmd_ready |=> !rsp_valid, "result appeared too early")

  // a flagged error carries a zero value
  `ICA_ASSERT(a_err_zero, clk, rst, rsp_valid && rsp_word.error_code != ica_pkg::ERR_OK |-> rsp_word.result_value == '0, "error result with nonzero value")

  // after a result leaves, the block is ready again
  `ICA_ASSERT(a_back_to_idle, clk, rst, rsp_valid && rsp_ready |=> cmd_ready, "not ready after result delivered")

endmodule

bind integer_calculator_alu ica_checker u_ica_checker (.*);

// ===== tb/sv/integer_calculator_alu_tb.sv =====
// testbench for integer_calculator_alu: directed corner words, then random words,
// each result checked against a behavioral predictor of all seven operations
// depends on ica_pkg and the integer_calculator_alu rtl
`timescale 1ns / 1ps

module integer_calculator_alu_tb;

  // mode 7 is left unused by the block and must answer zero with no error
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  localparam int RANDOM_WORDS   = 2000;
  localparam int QUIET_WORDS    = 300;   // final stretch with no idling on either side
  localparam int DRAIN_CYCLES   = 80;    // margin for stray words once the queue is empty
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no word moving on either channel

  // ---------------------------------------------------------------------------
  // predictor and queue of expected results
  // ---------------------------------------------------------------------------
  class alu_result_tracker;
    ica_pkg::rsp_word_t pending_results[$];
    int                 failures;

    function new();
      failures = 0;
    endfunction

    // result and error code of one command word
    function ica_pkg::rsp_word_t compute_result(ica_pkg::cmd_word_t c);
      logic [31:0]        a, b, res, acc, root, trial, prod;
      logic [63:0]        square;
      logic [1:0]         err;
      longint             quo;
      int                 i;
      ica_pkg::rsp_word_t r;
      a   = c.operand_a;
      b   = c.operand_b;
      res = '0;
      err = ica_pkg::ERR_OK;
      case (c.mode)
        ica_pkg::MODE_ADD: res = a + b;
        ica_pkg::MODE_SUB: res = a - b;
        ica_pkg::MODE_MUL: res = a * b;
        ica_pkg::MODE_DIV: begin
          // only the divisor is guarded; min / -1 wraps back to min
          if (b == '0) begin
            err = ica_pkg::ERR_DIV_ZERO;
          end else begin
            quo = longint'($signed(a)) / longint'($signed(b));
            res = quo[31:0];
          end
        end
        ica_pkg::MODE_POW: begin
          if (b[31]) begin
            // negative exponent: truncated value, zero base is an error
            if (a == '0) begin
              err = ica_pkg::ERR_ZERO_NEG_POW;
            end else if (a == 32'd1) begin
              res = 32'd1;
            end else if (a == 32'hffff_ffff) begin
              res = b[0] ? 32'hffff_ffff : 32'd1;
            end else begin
              res = '0;
            end
          end else begin
            // left-to-right square and multiply, wrapping to 32 bits
            acc = 32'd1;
            for (i = 31; i >= 0; i--) begin
              acc = acc * acc;
              if (b[i]) acc = acc * a;
            end
            res = acc;
          end
        end
        ica_pkg::MODE_SQRT: begin
          if (a[31]) begin
            err = ica_pkg::ERR_NEG_ROOT;
          end else begin
            // build the floor root one bit at a time from the top
            root = '0;
            for (i = 15; i >= 0; i--) begin
              trial  = root | (32'd1 << i);
              square = {32'd0, trial} * {32'd0, trial};
              if (square <= {32'd0, a}) root = trial;
            end
            res = root;
          end
        end
        ica_pkg::MODE_PCT: begin
          // product wraps first, then truncating divide
          prod = a * b;
          quo  = longint'($signed(prod)) / longint'(ica_pkg::PERCENT_DIVISOR);
          res  = quo[31:0];
        end
        default: res = '0;
      endcase
      if (err != ica_pkg::ERR_OK) res = '0;
      r.result_value = res;
      r.error_code   = err;
      return r;
    endfunction

    function void note_cmd(ica_pkg::cmd_word_t c);
      pending_results.push_back(compute_result(c));
    endfunction

    function void check_rsp(ica_pkg::rsp_word_t got);
      ica_pkg::rsp_word_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: result_value %0d error_code %0d",
               got.result_value, got.error_code);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.result_value !== want.result_value) begin
        $error("result_value: expected %0d, actual %0d", want.result_value, got.result_value);
        failures++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, actual %0d", want.error_code, got.error_code);
        failures++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block hookup
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_ready;
  ica_pkg::cmd_word_t cmd_word  = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  ica_pkg::rsp_word_t rsp_word;

  alu_result_tracker tracker;
  bit                quiet_tail = 1'b0;
  int                idle_cycles = 0;

  integer_calculator_alu dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // offer one word, hold it until taken, then maybe idle for a burst
  task automatic send_cmd(input logic [2:0] mode, input logic [31:0] a,
                          input logic [31:0] b);
    ica_pkg::cmd_word_t w;
    w.mode      = mode;
    w.operand_a = a;
    w.operand_b = b;
    cmd_word  <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    tracker.note_cmd(w);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // operand mix: full range, small values, extremes, shifted magnitudes
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 40) - 32'd20;
      2: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  // corner words: wraps, truncation, every error and each special case
  task automatic run_directed();
    send_cmd(ica_pkg::MODE_ADD, 32'h7fff_ffff, 32'd1);           // wraps to min
    send_cmd(ica_pkg::MODE_ADD, 32'h8000_0000, 32'h8000_0000);   // wraps to zero
    send_cmd(ica_pkg::MODE_SUB, 32'h8000_0000, 32'd1);
    send_cmd(ica_pkg::MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_cmd(ica_pkg::MODE_MUL, 32'h8000_0000, 32'hffff_ffff);
    send_cmd(ica_pkg::MODE_DIV, 32'd7, -32'd2);                  // truncates toward zero
    send_cmd(ica_pkg::MODE_DIV, -32'd7, 32'd2);
    send_cmd(ica_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);   // divide overflow wraps
    send_cmd(ica_pkg::MODE_DIV, 32'd0, 32'd0);                   // divide by zero, zero dividend
    send_cmd(ica_pkg::MODE_DIV, 32'd5, 32'd0);
    send_cmd(ica_pkg::MODE_POW, 32'd0, 32'd0);                   // zero to the zero is one
    send_cmd(ica_pkg::MODE_POW, 32'd0, -32'd1);                  // zero to a negative power
    send_cmd(ica_pkg::MODE_POW, 32'd1, -32'd5);
    send_cmd(ica_pkg::MODE_POW, -32'd1, -32'd3);                 // odd negative exponent
    send_cmd(ica_pkg::MODE_POW, -32'd1, -32'd4);                 // even negative exponent
    send_cmd(ica_pkg::MODE_POW, 32'd2, -32'd1);                  // truncated to zero
    send_cmd(ica_pkg::MODE_POW, 32'd3, 32'h7fff_ffff);           // longest exponent, wraps
    send_cmd(ica_pkg::MODE_SQRT, 32'h8000_0000, 32'hffff_ffff);  // negative root
    send_cmd(ica_pkg::MODE_SQRT, 32'd0, 32'd0);
    send_cmd(ica_pkg::MODE_SQRT, 32'd1, 32'h8000_0000);
    send_cmd(ica_pkg::MODE_SQRT, 32'h7fff_ffff, 32'd5);
    send_cmd(ica_pkg::MODE_PCT, 32'h7fff_ffff, 32'h7fff_ffff);   // product wraps before divide
    send_cmd(ica_pkg::MODE_PCT, -32'd150, 32'd1);
    send_cmd(MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic run_random();
    logic [2:0]  mode;
    logic [31:0] a, b, k;
    int          n;
    for (n = 0; n < RANDOM_WORDS; n++) begin
      quiet_tail = (n >= RANDOM_WORDS - QUIET_WORDS);
      mode = 3'($urandom_range(0, 7));
      a    = pick_operand();
      b    = pick_operand();
      // mostly modest exponents so the power results stay interesting
      if (mode == ica_pkg::MODE_POW && $urandom_range(0, 3) != 0) b = $urandom_range(0, 40);
      // perfect squares and their neighbors below
      if (mode == ica_pkg::MODE_SQRT && $urandom_range(0, 2) == 0) begin
        k = $urandom_range(1, 46340);
        a = k * k - $urandom_range(0, 1);
      end
      send_cmd(mode, a, b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: bursts of back pressure, none in the quiet tail
  // ---------------------------------------------------------------------------
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // values read here are the ones that stood at the edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_rsp(rsp_word);
  end

  // watchdog: no word moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("integer_calculator_alu regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random();
    cmd_valid <= 1'b0;
    // drain, then a margin for any stray word
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("integer_calculator_alu regression: pass");
    end else begin
      $display("integer_calculator_alu regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ica_pkg.sv
hdl/ica_shared_unit.sv
hdl/integer_calculator_alu.sv
hdl/ica_checker.sv
tb/sv/integer_calculator_alu_tb.sv
